FILE: hw/rtl/mrbs_pkg.sv
// Shared types, constants and CRC helper for the Modbus-RTU byte store slave.
package mrbs_pkg;

	localparam int STORE_BYTES     = 256;
	localparam int MAX_WRITE_BYTES = 64;
	localparam int MAX_READ_BYTES  = 58;

	localparam int ST_AW = $clog2(STORE_BYTES);
	localparam int FR_AW = $clog2(MAX_WRITE_BYTES);
	localparam int CNT_W = (ST_AW > 7) ? ST_AW : 7;

	localparam logic [7:0]  RESTART_BYTE     = 8'hEA;
	localparam logic [7:0]  CMD_WRITE        = 8'h10;
	localparam logic [7:0]  CMD_READ         = 8'h03;
	localparam logic [7:0]  CMD_IDENT        = 8'h44;
	localparam logic [7:0]  DEV_ADDR_RST     = 8'd85;
	localparam logic [6:0]  WRITE_DATA_START = 7'd7;
	localparam logic [8:0]  WRITE_OVERHEAD   = 9'd9;
	localparam logic [6:0]  READ_FRAME_LEN   = 7'd8;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;

	typedef struct packed {
		logic       mode;
		logic [7:0] rx_byte;
		logic       line_error;
	} req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
		logic       restart_request;
	} rsp_t;

	typedef enum logic [3:0] {
		SEL_RESTART,
		SEL_DEV,
		SEL_HDR,
		SEL_READ_CMD,
		SEL_IDENT_CMD,
		SEL_COUNT,
		SEL_STORE,
		SEL_CRC_LO,
		SEL_CRC_HI
	} out_sel_t;

	typedef struct packed {
		logic             rx_wr;
		logic [6:0]       rx_pos;
		logic             fr_wr;
		logic [FR_AW-1:0] fr_waddr;
		logic             fr_rd;
		logic [FR_AW-1:0] fr_raddr;
		logic             st_rd;
		logic             st_wr;
		logic             st_clr;
		logic [ST_AW-1:0] st_addr;
		logic             out_load;
		out_sel_t         out_sel;
		logic [2:0]       out_hdr_idx;
		logic             out_first;
		logic             out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic       out_free;
		logic       crc_ok;
		logic [7:0] dev_addr;
		logic [7:0] base;
		logic [7:0] wr_count;
		logic [7:0] num_lo;
	} dp_sts_t;

	// CRC-16/Modbus, reflected, one byte
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/modbus_rtu_byte_store_slave_core.sv
// Top level of the Modbus-RTU byte store slave core.
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  req     | req_valid, req_ready, req      | to core
//  rsp     | rsp_valid, rsp_ready, rsp      | from core
//  cfg     | cfg_we, cfg_wdata              | to core
//
// An identify command byte, or the last byte of a valid write or read frame, starts
// the sequencer: identify reply, store copy then header echo, or read reply.
// Reply bytes go out one per cycle at most, gated by the single reply register.
// After reset the 256-entry store is zeroed one entry per cycle.
// req_ready is low while a reply, copy or clear is in progress or a reply byte waits.
module modbus_rtu_byte_store_slave_core import mrbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	mrbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.sts       (sts),
		.cmd       (cmd)
	);

	mrbs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

FILE: hw/rtl/mrbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/mrbs_datapath.sv
// Datapath: address register, frame header, CRCs, frame and store RAMs, reply register.
module mrbs_datapath import mrbs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic [7:0] cfg_wdata,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output rsp_t    rsp
);

	logic [7:0]  dev_q;
	logic [7:0]  hdr_q [7];
	logic [7:0]  prev_q;
	logic [15:0] crc_q;
	logic [15:0] crc_m1_q;
	logic [15:0] rcrc_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic [7:0]  fr_rdata;
	logic [7:0]  st_rdata;
	logic [7:0]  out_byte;
	logic        out_crc_upd;

	mrbs_ram #(.WIDTH(8), .DEPTH(MAX_WRITE_BYTES)) u_frame_ram (
		.clk   (clk),
		.we    (cmd.fr_wr),
		.waddr (cmd.fr_waddr),
		.wdata (req.rx_byte),
		.re    (cmd.fr_rd),
		.raddr (cmd.fr_raddr),
		.rdata (fr_rdata)
	);

	mrbs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store_ram (
		.clk   (clk),
		.we    (cmd.st_wr | cmd.st_clr),
		.waddr (cmd.st_addr),
		.wdata (cmd.st_clr ? 8'h00 : fr_rdata),
		.re    (cmd.st_rd),
		.raddr (cmd.st_addr),
		.rdata (st_rdata)
	);

	always_comb begin
		out_crc_upd = 1'b1;
		unique case (cmd.out_sel)
			SEL_RESTART: begin
				out_byte    = 8'h00;
				out_crc_upd = 1'b0;
			end
			SEL_DEV:       out_byte = dev_q;
			SEL_HDR:       out_byte = hdr_q[cmd.out_hdr_idx];
			SEL_READ_CMD:  out_byte = CMD_READ;
			SEL_IDENT_CMD: out_byte = CMD_IDENT;
			SEL_COUNT:     out_byte = {hdr_q[5][6:0], 1'b0};
			SEL_STORE:     out_byte = st_rdata;
			SEL_CRC_LO: begin
				out_byte    = rcrc_q[7:0];
				out_crc_upd = 1'b0;
			end
			SEL_CRC_HI: begin
				out_byte    = rcrc_q[15:8];
				out_crc_upd = 1'b0;
			end
			default: begin
				out_byte    = 8'h00;
				out_crc_upd = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q       <= DEV_ADDR_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dev_q <= cfg_wdata;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rx_wr) begin
			if (cmd.rx_pos < 7'd7) begin
				hdr_q[cmd.rx_pos[2:0]] <= req.rx_byte;
			end
			prev_q   <= req.rx_byte;
			crc_m1_q <= crc_q;
			crc_q    <= crc_update((cmd.rx_pos == 7'd0) ? CRC_INIT : crc_q, req.rx_byte);
		end
		if (cmd.out_load) begin
			rsp_q.tx_byte         <= out_byte;
			rsp_q.last            <= cmd.out_last;
			rsp_q.restart_request <= (cmd.out_sel == SEL_RESTART);
			if (out_crc_upd) begin
				rcrc_q <= crc_update(cmd.out_first ? CRC_INIT : rcrc_q, out_byte);
			end
		end
	end

	// crc_m1_q covers every byte but the last two, which are the received CRC
	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign sts.crc_ok   = (crc_m1_q == {req.rx_byte, prev_q});
	assign sts.dev_addr = dev_q;
	assign sts.base     = hdr_q[3];
	assign sts.wr_count = hdr_q[6];
	assign sts.num_lo   = hdr_q[5];

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hw/rtl/mrbs_ctrl.sv
// Controller: frame parser and reply/copy/clear sequencer.
module mrbs_ctrl import mrbs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  req_t    req,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_RX,
		S_ID,
		S_WR_RD,
		S_WR_PUT,
		S_ECHO,
		S_RD_HDR,
		S_RD_REQ,
		S_RD_EMIT,
		S_CRC_LO,
		S_CRC_HI
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_CMD,
		PH_WRITE,
		PH_READ
	} phase_t;

	state_t           state_q;
	phase_t           phase_q;
	logic [6:0]       idx_q;
	logic [CNT_W-1:0] cnt_q;

	logic             acc;
	logic [6:0]       nidx;
	logic [CNT_W-1:0] cnt_nx;
	logic [8:0]       rd_count;
	logic [8:0]       wr_end;
	logic [8:0]       wr_data_end;
	logic [9:0]       addr_sum;
	logic [9:0]       wr_span;
	logic [9:0]       rd_span;
	logic             wr_count_done;
	logic             rd_count_done;
	logic [6:0]       fr_off;

	assign req_ready     = (state_q == S_RX) && sts.out_free;
	assign acc           = req_valid && req_ready;
	assign nidx          = idx_q + 7'd1;
	assign cnt_nx        = cnt_q + 1'b1;
	assign rd_count      = {sts.num_lo, 1'b0};
	assign wr_end        = {1'b0, sts.wr_count} + WRITE_OVERHEAD;
	assign wr_data_end   = {1'b0, sts.wr_count} + {2'b00, WRITE_DATA_START};
	assign addr_sum      = {2'b00, sts.base} + 10'(cnt_q);
	assign wr_span       = {2'b00, sts.base} + {2'b00, sts.wr_count};
	assign rd_span       = {2'b00, sts.base} + {1'b0, rd_count};
	assign wr_count_done = (10'(cnt_nx) == {2'b00, sts.wr_count});
	assign rd_count_done = (10'(cnt_nx) == {1'b0, rd_count});
	assign fr_off        = idx_q - WRITE_DATA_START;

	always_comb begin
		cmd             = '0;
		cmd.out_sel     = SEL_DEV;
		cmd.rx_pos      = idx_q;
		cmd.fr_waddr    = fr_off[FR_AW-1:0];
		cmd.fr_raddr    = cnt_q[FR_AW-1:0];
		cmd.st_addr     = addr_sum[ST_AW-1:0];
		cmd.out_hdr_idx = cnt_q[2:0];
		unique case (state_q)
			S_CLEAR: begin
				cmd.st_clr  = 1'b1;
				cmd.st_addr = cnt_q[ST_AW-1:0];
			end
			S_RX: begin
				if (acc && !req.mode) begin
					if (phase_q == PH_IDLE) begin
						if (req.rx_byte == RESTART_BYTE) begin
							cmd.out_load = 1'b1;
							cmd.out_sel  = SEL_RESTART;
						end else if (req.rx_byte == sts.dev_addr && !req.line_error) begin
							cmd.rx_wr = 1'b1;
						end
					end else if (!req.line_error) begin
						cmd.rx_wr = 1'b1;
						cmd.fr_wr = (phase_q == PH_WRITE) && (idx_q >= WRITE_DATA_START)
							&& ({2'b00, idx_q} < wr_data_end);
					end
				end
			end
			S_ID: begin
				cmd.out_load  = sts.out_free;
				cmd.out_first = (cnt_q == '0);
				cmd.out_sel   = (cnt_q == CNT_W'(1)) ? SEL_IDENT_CMD : SEL_DEV;
			end
			S_WR_RD: begin
				cmd.fr_rd = 1'b1;
			end
			S_WR_PUT: begin
				cmd.st_wr = 1'b1;
			end
			S_ECHO: begin
				cmd.out_load  = sts.out_free;
				cmd.out_first = (cnt_q == '0);
				cmd.out_sel   = SEL_HDR;
			end
			S_RD_HDR: begin
				cmd.out_load  = sts.out_free;
				cmd.out_first = (cnt_q == '0);
				priority if (cnt_q == '0) begin
					cmd.out_sel = SEL_DEV;
				end else if (cnt_q == CNT_W'(1)) begin
					cmd.out_sel = SEL_READ_CMD;
				end else begin
					cmd.out_sel = SEL_COUNT;
				end
			end
			S_RD_REQ: begin
				cmd.st_rd = 1'b1;
			end
			S_RD_EMIT: begin
				cmd.out_load = sts.out_free;
				cmd.out_sel  = SEL_STORE;
			end
			S_CRC_LO: begin
				cmd.out_load = sts.out_free;
				cmd.out_sel  = SEL_CRC_LO;
			end
			S_CRC_HI: begin
				cmd.out_load = sts.out_free;
				cmd.out_sel  = SEL_CRC_HI;
				cmd.out_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_nx;
					if (cnt_q[ST_AW-1:0] == ST_AW'(STORE_BYTES - 1)) begin
						cnt_q   <= '0;
						state_q <= S_RX;
					end
				end
				S_RX: begin
					if (acc) begin
						cnt_q <= '0;
						priority if (req.mode) begin
							phase_q <= PH_IDLE;
							idx_q   <= '0;
						end else if (phase_q == PH_IDLE) begin
							if (req.rx_byte != RESTART_BYTE && req.rx_byte == sts.dev_addr
								&& !req.line_error) begin
								phase_q <= PH_CMD;
								idx_q   <= 7'd1;
							end
						end else if (req.line_error) begin
							phase_q <= PH_IDLE;
							idx_q   <= '0;
						end else if (phase_q == PH_CMD) begin
							idx_q <= 7'd2;
							priority if (req.rx_byte == CMD_WRITE) begin
								phase_q <= PH_WRITE;
							end else if (req.rx_byte == CMD_READ) begin
								phase_q <= PH_READ;
							end else begin
								phase_q <= PH_IDLE;
								idx_q   <= '0;
								if (req.rx_byte == CMD_IDENT) begin
									state_q <= S_ID;
								end
							end
						end else if (phase_q == PH_WRITE) begin
							idx_q <= nidx;
							if (nidx == WRITE_DATA_START
								&& req.rx_byte > 8'(MAX_WRITE_BYTES)) begin
								phase_q <= PH_IDLE;
								idx_q   <= '0;
							end else if (nidx >= WRITE_DATA_START && {2'b00, nidx} == wr_end) begin
								phase_q <= PH_IDLE;
								idx_q   <= '0;
								if (sts.crc_ok && wr_span <= 10'(STORE_BYTES)) begin
									state_q <= (sts.wr_count == 8'd0) ? S_ECHO : S_WR_RD;
								end
							end
						end else begin
							idx_q <= nidx;
							if (nidx >= READ_FRAME_LEN) begin
								phase_q <= PH_IDLE;
								idx_q   <= '0;
								if (sts.crc_ok && rd_count <= 9'(MAX_READ_BYTES)
									&& rd_span <= 10'(STORE_BYTES)) begin
									state_q <= S_RD_HDR;
								end
							end
						end
					end
				end
				S_ID: begin
					if (sts.out_free) begin
						cnt_q <= cnt_nx;
						if (cnt_q == CNT_W'(2)) begin
							state_q <= S_CRC_LO;
						end
					end
				end
				S_WR_RD: begin
					state_q <= S_WR_PUT;
				end
				S_WR_PUT: begin
					cnt_q   <= cnt_nx;
					state_q <= S_WR_RD;
					if (wr_count_done) begin
						cnt_q   <= '0;
						state_q <= S_ECHO;
					end
				end
				S_ECHO: begin
					if (sts.out_free) begin
						cnt_q <= cnt_nx;
						if (cnt_q == CNT_W'(5)) begin
							state_q <= S_CRC_LO;
						end
					end
				end
				S_RD_HDR: begin
					if (sts.out_free) begin
						cnt_q <= cnt_nx;
						if (cnt_q == CNT_W'(2)) begin
							cnt_q   <= '0;
							state_q <= (rd_count == 9'd0) ? S_CRC_LO : S_RD_REQ;
						end
					end
				end
				S_RD_REQ: begin
					state_q <= S_RD_EMIT;
				end
				S_RD_EMIT: begin
					if (sts.out_free) begin
						cnt_q   <= cnt_nx;
						state_q <= rd_count_done ? S_CRC_LO : S_RD_REQ;
					end
				end
				S_CRC_LO: begin
					if (sts.out_free) begin
						state_q <= S_CRC_HI;
					end
				end
				S_CRC_HI: begin
					if (sts.out_free) begin
						state_q <= S_RX;
					end
				end
				default: state_q <= S_RX;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("reply register loaded while occupied");
	a_no_rx_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !req_ready)
		else $error("request taken during store clear");
	a_store_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.st_wr && cmd.st_clr) && !(cmd.st_rd && (cmd.st_wr || cmd.st_clr)))
		else $error("store port conflict");
	a_crc_hi_follows_lo: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CRC_LO && sts.out_free) |=> (state_q == S_CRC_HI))
		else $error("CRC high byte did not follow low byte");
`endif

endmodule
